>>> hdl/lpis_pkg.sv
// Shared types, constants and register codes for the terrain quad index stitcher.
package lpis_pkg;

  // Field widths
  localparam int unsigned PatchW    = 9;
  localparam int unsigned QuadW     = 7;
  localparam int unsigned LodW      = 3;
  localparam int unsigned NbLodW    = 4;
  localparam int unsigned MapSideW  = 13;
  localparam int unsigned CellsLogW = 3;
  localparam int unsigned IdxW      = 25;
  localparam int unsigned CfgDataW  = 13;
  localparam int unsigned CfgIdxW   = 1;

  // Patch-local vertex coordinate: quad origin plus step, up to 255
  localparam int unsigned VtxW   = 8;
  // Global vertex coordinate: local coordinate plus patch offset
  localparam int unsigned CoordW = 17;

  // Register reset values
  localparam logic [MapSideW-1:0]  MapSideRst  = 13'd257;
  localparam logic [CellsLogW-1:0] CellsLogRst = 3'd5;

  // Default queue depth between front and back
  localparam int unsigned QueueDepthDef = 2;

  // Corner order inside a quad beat
  localparam int unsigned NumCorners = 4;
  localparam int unsigned CornerOO   = 0;  // (x,   z)
  localparam int unsigned CornerSO   = 1;  // (x+s, z)
  localparam int unsigned CornerOS   = 2;  // (x,   z+s)
  localparam int unsigned CornerSS   = 3;  // (x+s, z+s)

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAP_SIDE        = 1'd0,
    CFG_PATCH_CELLS_LOG2 = 1'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
  } corner_t;

  typedef corner_t [NumCorners-1:0] quad_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_stat_t;

endpackage

>>> hdl/lpis_front.sv
// Front end: snaps and clamps the four quad corners and forms their global coordinates.
module lpis_front (
  input  logic                              start_i,
  input  logic                              queue_full_i,
  input  logic [lpis_pkg::CellsLogW-1:0]    patch_cells_log2_i,
  input  logic [lpis_pkg::PatchW-1:0]       patch_col_i,
  input  logic [lpis_pkg::PatchW-1:0]       patch_row_i,
  input  logic [lpis_pkg::QuadW-1:0]        quad_x_i,
  input  logic [lpis_pkg::QuadW-1:0]        quad_z_i,
  input  logic [lpis_pkg::LodW-1:0]         own_lod_i,
  input  logic signed [lpis_pkg::NbLodW-1:0] top_lod_i,
  input  logic signed [lpis_pkg::NbLodW-1:0] bottom_lod_i,
  input  logic signed [lpis_pkg::NbLodW-1:0] left_lod_i,
  input  logic signed [lpis_pkg::NbLodW-1:0] right_lod_i,
  output logic                              push_o,
  output lpis_pkg::quad_t                   quad_o
);
  import lpis_pkg::*;

  // True when the neighbor is present, coarser, and pos is off its grid
  function automatic logic needs_snap(logic signed [NbLodW-1:0] nb, logic [LodW-1:0] own,
                                      logic [VtxW-1:0] pos);
    logic [VtxW-1:0] mask;
    mask = VtxW'((VtxW'(1) << nb[LodW-1:0]) - VtxW'(1));
    return !nb[NbLodW-1] && (own < nb[LodW-1:0]) && ((pos & mask) != '0);
  endfunction

  // Drop pos onto the neighbor's grid
  function automatic logic [VtxW-1:0] snap_down(logic signed [NbLodW-1:0] nb,
                                                logic [VtxW-1:0] pos);
    logic [VtxW-1:0] mask;
    mask = VtxW'((VtxW'(1) << nb[LodW-1:0]) - VtxW'(1));
    return pos & ~mask;
  endfunction

  logic [VtxW-1:0] cells;
  logic [VtxW-1:0] step;
  logic [VtxW-1:0] x_lo, x_hi, z_lo, z_hi;
  logic [CoordW-1:0] col_base, row_base;
  logic [VtxW-1:0] vx_in [NumCorners];
  logic [VtxW-1:0] vz_in [NumCorners];

  assign cells    = VtxW'(VtxW'(1) << patch_cells_log2_i);
  assign step     = VtxW'(VtxW'(1) << own_lod_i);
  assign x_lo     = VtxW'(quad_x_i);
  assign z_lo     = VtxW'(quad_z_i);
  assign x_hi     = VtxW'(quad_x_i) + step;
  assign z_hi     = VtxW'(quad_z_i) + step;
  assign col_base = CoordW'(patch_col_i) << patch_cells_log2_i;
  assign row_base = CoordW'(patch_row_i) << patch_cells_log2_i;

  assign vx_in[CornerOO] = x_lo;  assign vz_in[CornerOO] = z_lo;
  assign vx_in[CornerSO] = x_hi;  assign vz_in[CornerSO] = z_lo;
  assign vx_in[CornerOS] = x_lo;  assign vz_in[CornerOS] = z_hi;
  assign vx_in[CornerSS] = x_hi;  assign vz_in[CornerSS] = z_hi;

  // Snap each corner along x, then along z, then clamp to the patch
  for (genvar c = 0; c < NumCorners; c++) begin : g_corner
    logic [VtxW-1:0] vx_s, vz_s, vx_c, vz_c;

    always_comb begin
      vx_s = vx_in[c];
      if (vz_in[c] == '0 && needs_snap(top_lod_i, own_lod_i, vx_in[c])) begin
        vx_s = snap_down(top_lod_i, vx_in[c]);
      end else if (vz_in[c] == cells && needs_snap(bottom_lod_i, own_lod_i, vx_in[c])) begin
        vx_s = snap_down(bottom_lod_i, vx_in[c]);
      end

      vz_s = vz_in[c];
      if (vx_s == '0 && needs_snap(left_lod_i, own_lod_i, vz_in[c])) begin
        vz_s = snap_down(left_lod_i, vz_in[c]);
      end else if (vx_s == cells && needs_snap(right_lod_i, own_lod_i, vz_in[c])) begin
        vz_s = snap_down(right_lod_i, vz_in[c]);
      end

      vx_c = (vx_s > cells) ? cells : vx_s;
      vz_c = (vz_s > cells) ? cells : vz_s;
    end

    assign quad_o[c].col = col_base + CoordW'(vx_c);
    assign quad_o[c].row = row_base + CoordW'(vz_c);
  end

  assign push_o = start_i && !queue_full_i;

endmodule

>>> hdl/lpis_queue.sv
// Short queue of classified quad beats between front and back.
module lpis_queue #(
  parameter int unsigned DEPTH = lpis_pkg::QueueDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  lpis_pkg::quad_t       data_i,
  input  logic                  pop_i,
  output lpis_pkg::quad_t       data_o,
  output lpis_pkg::queue_stat_t stat_o
);
  import lpis_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  quad_t           mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_pop;

  assign do_pop = pop_i && (count_q != '0);

  // Advance pointers with wrap at the depth and track the fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.valid = (count_q != '0);
  assign stat_o.full  = (count_q == CntW'(DEPTH));

endmodule

>>> hdl/lpis_back.sv
// Back end: multiplies rows by the map side and adds columns, two register stages.
module lpis_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lpis_pkg::queue_stat_t           queue_stat_i,
  input  lpis_pkg::quad_t                 quad_i,
  input  logic [lpis_pkg::MapSideW-1:0]   map_side_i,
  output logic                            pop_o,
  output logic                            done_o,
  output logic [lpis_pkg::IdxW-1:0]       idx_oo_o,
  output logic [lpis_pkg::IdxW-1:0]       idx_so_o,
  output logic [lpis_pkg::IdxW-1:0]       idx_os_o,
  output logic [lpis_pkg::IdxW-1:0]       idx_ss_o
);
  import lpis_pkg::*;

  localparam int unsigned ProdW = CoordW + MapSideW;

  logic              mul_vld_q, out_vld_q;
  logic [IdxW-1:0]   prod_q [NumCorners];
  logic [CoordW-1:0] col_q  [NumCorners];
  logic [IdxW-1:0]   idx_q  [NumCorners];

  // The receiver never stalls, so drain one beat each cycle whenever the queue holds one
  assign pop_o = queue_stat_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      mul_vld_q <= queue_stat_i.valid;
      out_vld_q <= mul_vld_q;
    end
  end

  // Stage one: row times map side, keep the low index bits; stage two adds the column
  for (genvar c = 0; c < NumCorners; c++) begin : g_mul
    logic [IdxW-1:0] prod;
    assign prod = IdxW'(ProdW'(quad_i[c].row) * ProdW'(map_side_i));

    always_ff @(posedge clk_i) begin
      prod_q[c] <= prod;
      col_q[c]  <= quad_i[c].col;
      idx_q[c]  <= prod_q[c] + IdxW'(col_q[c]);
    end
  end

  assign done_o   = out_vld_q;
  assign idx_oo_o = idx_q[CornerOO];
  assign idx_so_o = idx_q[CornerSO];
  assign idx_os_o = idx_q[CornerOS];
  assign idx_ss_o = idx_q[CornerSS];

endmodule

>>> hdl/lod_patch_index_stitch.sv
// Top level of the crack-free terrain quad index generator.
//
// Usage: raise start_i with one quad on the input ports; the beat is taken at
// the rising edge where start_i is high and busy_o is low. Each beat names a
// patch, the quad origin inside it, its level of detail and the levels of its
// four neighbors (negative means absent). The six triangle indices appear on
// tri0_*/tri1_* for exactly one cycle, marked by done_o, and must be taken
// then: the receiver cannot hold them off.
// done_o marks a beat once it has passed the queue and both back-end stages.
// Throughput: one quad per cycle while busy_o is low, set by the combinational
// corner front end and the two-stage multiply/add back end, which pops the
// queue whenever it holds a beat. busy_o shows a full front/back queue; with
// the back end never stalled it stays low for a QUEUE_DEPTH of two or more.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at the
// clock edge; write only while no quad is in flight.
// Reset clears the queue and pipeline valids and restores map side 257 and
// patch cells log2 of 5.
module lod_patch_index_stitch #(
  parameter int unsigned QUEUE_DEPTH = lpis_pkg::QueueDepthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lpis_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [lpis_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [lpis_pkg::PatchW-1:0]        patch_col_i,
  input  logic [lpis_pkg::PatchW-1:0]        patch_row_i,
  input  logic [lpis_pkg::QuadW-1:0]         quad_x_i,
  input  logic [lpis_pkg::QuadW-1:0]         quad_z_i,
  input  logic [lpis_pkg::LodW-1:0]          own_lod_i,
  input  logic signed [lpis_pkg::NbLodW-1:0] top_lod_i,
  input  logic signed [lpis_pkg::NbLodW-1:0] bottom_lod_i,
  input  logic signed [lpis_pkg::NbLodW-1:0] left_lod_i,
  input  logic signed [lpis_pkg::NbLodW-1:0] right_lod_i,
  output logic                               done_o,
  output logic [lpis_pkg::IdxW-1:0]          tri0_a_o,
  output logic [lpis_pkg::IdxW-1:0]          tri0_b_o,
  output logic [lpis_pkg::IdxW-1:0]          tri0_c_o,
  output logic [lpis_pkg::IdxW-1:0]          tri1_a_o,
  output logic [lpis_pkg::IdxW-1:0]          tri1_b_o,
  output logic [lpis_pkg::IdxW-1:0]          tri1_c_o
);
  import lpis_pkg::*;

  logic [MapSideW-1:0]  map_side_q;
  logic [CellsLogW-1:0] cells_log2_q;
  logic                 push, pop;
  quad_t                front_quad, queue_quad;
  queue_stat_t          queue_stat;
  logic [IdxW-1:0]      idx_oo, idx_so, idx_os, idx_ss;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_side_q   <= MapSideRst;
      cells_log2_q <= CellsLogRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_MAP_SIDE:         map_side_q   <= cfg_data_i[MapSideW-1:0];
        CFG_PATCH_CELLS_LOG2: cells_log2_q <= cfg_data_i[CellsLogW-1:0];
        default:              ;
      endcase
    end
  end

  lpis_front u_front (
    .start_i            (start_i),
    .queue_full_i       (queue_stat.full),
    .patch_cells_log2_i (cells_log2_q),
    .patch_col_i        (patch_col_i),
    .patch_row_i        (patch_row_i),
    .quad_x_i           (quad_x_i),
    .quad_z_i           (quad_z_i),
    .own_lod_i          (own_lod_i),
    .top_lod_i          (top_lod_i),
    .bottom_lod_i       (bottom_lod_i),
    .left_lod_i         (left_lod_i),
    .right_lod_i        (right_lod_i),
    .push_o             (push),
    .quad_o             (front_quad)
  );

  lpis_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_quad),
    .pop_i  (pop),
    .data_o (queue_quad),
    .stat_o (queue_stat)
  );

  lpis_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .queue_stat_i (queue_stat),
    .quad_i       (queue_quad),
    .map_side_i   (map_side_q),
    .pop_o        (pop),
    .done_o       (done_o),
    .idx_oo_o     (idx_oo),
    .idx_so_o     (idx_so),
    .idx_os_o     (idx_os),
    .idx_ss_o     (idx_ss)
  );

  assign busy_o   = queue_stat.full;

  // Two triangles sharing the origin and far corner
  assign tri0_a_o = idx_oo;
  assign tri0_b_o = idx_os;
  assign tri0_c_o = idx_ss;
  assign tri1_a_o = idx_oo;
  assign tri1_b_o = idx_ss;
  assign tri1_c_o = idx_so;

endmodule

>>> hdl/lpis_checker.sv
// Port-level checker for the quad index generator, bound to the top level.
module lpis_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic                        done_o,
  input logic [lpis_pkg::IdxW-1:0]   tri0_a_o,
  input logic [lpis_pkg::IdxW-1:0]   tri0_c_o,
  input logic [lpis_pkg::IdxW-1:0]   tri1_a_o,
  input logic [lpis_pkg::IdxW-1:0]   tri1_b_o
);
  import lpis_pkg::*;

  // Every accepted beat comes out through the queue and both back-end stages
  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##3 done_o)
    else $error("accepted quad produced no result");

  // No result without a beat accepted earlier at the input
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 3))
    else $error("result without an accepted quad");

  // The back end pops the queue whenever it holds a beat, so with a depth of two or more the queue never fills
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("queue filled up");

  // Both triangles share the origin and the far corner
  a_shared_corners: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (tri0_a_o == tri1_a_o) && (tri0_c_o == tri1_b_o))
    else $error("triangles disagree on shared corners");

endmodule

bind lod_patch_index_stitch lpis_checker u_lpis_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .tri0_a_o (tri0_a_o),
  .tri0_c_o (tri0_c_o),
  .tri1_a_o (tri1_a_o),
  .tri1_b_o (tri1_b_o)
);

>>> tb/lod_patch_index_stitch_test.sv
// Self-checking testbench for the crack-free terrain quad index generator.
module lod_patch_index_stitch_test;
  import lpis_pkg::*;

  typedef struct packed {
    logic [PatchW-1:0]        patch_col;
    logic [PatchW-1:0]        patch_row;
    logic [QuadW-1:0]         quad_x;
    logic [QuadW-1:0]         quad_z;
    logic [LodW-1:0]          own_lod;
    logic signed [NbLodW-1:0] top_lod;
    logic signed [NbLodW-1:0] bottom_lod;
    logic signed [NbLodW-1:0] left_lod;
    logic signed [NbLodW-1:0] right_lod;
  } quad_req_t;

  localparam int unsigned ReqW = $bits(quad_req_t);

  // Six triangle indices; entry 0 is tri0_a, entry 5 is tri1_c
  typedef logic [5:0][IdxW-1:0] tri_set_t;

  localparam int unsigned NumPhases = 10;
  localparam int unsigned QuadsPerPhase = 155;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx_i = CFG_MAP_SIDE;
  logic [CfgDataW-1:0]      cfg_data_i = '0;
  logic                     start_i = 1'b0;
  logic                     busy_o;
  logic [PatchW-1:0]        patch_col_i = '0;
  logic [PatchW-1:0]        patch_row_i = '0;
  logic [QuadW-1:0]         quad_x_i = '0;
  logic [QuadW-1:0]         quad_z_i = '0;
  logic [LodW-1:0]          own_lod_i = '0;
  logic signed [NbLodW-1:0] top_lod_i = '0;
  logic signed [NbLodW-1:0] bottom_lod_i = '0;
  logic signed [NbLodW-1:0] left_lod_i = '0;
  logic signed [NbLodW-1:0] right_lod_i = '0;
  logic                     done_o;
  logic [IdxW-1:0]          tri0_a_o, tri0_b_o, tri0_c_o;
  logic [IdxW-1:0]          tri1_a_o, tri1_b_o, tri1_c_o;

  // Shadow copy of the block's registers
  logic [MapSideW-1:0]  map_side_q = MapSideRst;
  logic [CellsLogW-1:0] cells_log2_q = CellsLogRst;

  quad_req_t quad_queue[$];
  tri_set_t  expected_tris[$];
  quad_req_t cur_quad;
  int unsigned quads_planned = 0;
  int unsigned quads_checked = 0;
  int unsigned settings_run = 1;
  int unsigned mismatches = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  bit steady = 1'b0;
  string field_name[6] = '{"tri0_a", "tri0_b", "tri0_c", "tri1_a", "tri1_b", "tri1_c"};

  int unsigned side_tab[NumPhases] = '{9, 4097, 0, 8191, 1000, 513, 257, 4097, 9, 8191};
  int unsigned log2_tab[NumPhases] = '{3, 7, 2, 0, 4, 6, 5, 3, 7, 1};

  lod_patch_index_stitch dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start_i, .busy_o,
    .patch_col_i, .patch_row_i, .quad_x_i, .quad_z_i, .own_lod_i,
    .top_lod_i, .bottom_lod_i, .left_lod_i, .right_lod_i, .done_o,
    .tri0_a_o, .tri0_b_o, .tri0_c_o, .tri1_a_o, .tri1_b_o, .tri1_c_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Neighbor level as a signed number; any negative value means absent
  function automatic int lod_of(logic [NbLodW-1:0] v);
    return v[NbLodW-1] ? int'(v) - 16 : int'(v);
  endfunction

  // True when the neighbor is present, coarser, and pos is off its grid
  function automatic bit off_grid(int nb, int own, int unsigned pos);
    if (nb < 0 || own >= nb) return 1'b0;
    return (pos & ((32'd1 << nb) - 1)) != 0;
  endfunction

  function automatic int unsigned snap_down(int nb, int unsigned pos);
    return pos & ~((32'd1 << nb) - 1);
  endfunction

  // Vertex index of one corner after edge snapping and clamping
  function automatic logic [IdxW-1:0] corner_index(int unsigned vx, int unsigned vz,
                                                   quad_req_t q);
    int unsigned cells;
    int own;
    longint unsigned row, col;
    cells = 32'd1 << cells_log2_q;
    own = int'(q.own_lod);
    if (vz == 0 && off_grid(lod_of(q.top_lod), own, vx)) begin
      vx = snap_down(lod_of(q.top_lod), vx);
    end else if (vz == cells && off_grid(lod_of(q.bottom_lod), own, vx)) begin
      vx = snap_down(lod_of(q.bottom_lod), vx);
    end
    if (vx == 0 && off_grid(lod_of(q.left_lod), own, vz)) begin
      vz = snap_down(lod_of(q.left_lod), vz);
    end else if (vx == cells && off_grid(lod_of(q.right_lod), own, vz)) begin
      vz = snap_down(lod_of(q.right_lod), vz);
    end
    if (vz > cells) vz = cells;
    if (vx > cells) vx = cells;
    row = longint'(vz) + longint'(cells) * q.patch_row;
    col = longint'(vx) + longint'(cells) * q.patch_col;
    return IdxW'(row * map_side_q + col);
  endfunction

  // Expected triangle indices for one quad
  function automatic tri_set_t stitch_quad(quad_req_t q);
    int unsigned s, x0, z0;
    logic [IdxW-1:0] i_oo, i_so, i_os, i_ss;
    s = 32'd1 << q.own_lod;
    x0 = 32'(q.quad_x);
    z0 = 32'(q.quad_z);
    i_oo = corner_index(x0, z0, q);
    i_so = corner_index(x0 + s, z0, q);
    i_os = corner_index(x0, z0 + s, q);
    i_ss = corner_index(x0 + s, z0 + s, q);
    return {i_so, i_ss, i_oo, i_ss, i_os, i_oo};
  endfunction

  function automatic logic [NbLodW-1:0] pick_neighbor(int unsigned own);
    case ($urandom_range(0, 7))
      0: return 4'hF;
      1: return 4'($urandom_range(8, 15));
      2, 3, 4: return 4'((own < 7) ? $urandom_range(own + 1, 7) : own);
      default: return 4'($urandom_range(0, 7));
    endcase
  endfunction

  // Tidy quads sit on the step grid inside the patch, often on an edge
  function automatic quad_req_t make_quad(bit tidy);
    quad_req_t q;
    int unsigned own, nq, ix, iz;
    q = quad_req_t'(ReqW'({$urandom, $urandom}));
    if (tidy) begin
      own = $urandom_range(0, cells_log2_q);
      nq = (32'd1 << cells_log2_q) >> own;
      ix = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? 0 : nq - 1)
                                : $urandom_range(0, nq - 1);
      iz = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? 0 : nq - 1)
                                : $urandom_range(0, nq - 1);
      q.own_lod = LodW'(own);
      q.quad_x = QuadW'(ix << own);
      q.quad_z = QuadW'(iz << own);
      q.top_lod = pick_neighbor(own);
      q.bottom_lod = pick_neighbor(own);
      q.left_lod = pick_neighbor(own);
      q.right_lod = pick_neighbor(own);
    end
    return q;
  endfunction

  task automatic push_quad(int col, int row, int qx, int qz, int own,
                           int top, int bot, int lft, int rgt);
    quad_req_t q;
    q.patch_col = PatchW'(col);
    q.patch_row = PatchW'(row);
    q.quad_x = QuadW'(qx);
    q.quad_z = QuadW'(qz);
    q.own_lod = LodW'(own);
    q.top_lod = NbLodW'(top);
    q.bottom_lod = NbLodW'(bot);
    q.left_lod = NbLodW'(lft);
    q.right_lod = NbLodW'(rgt);
    quad_queue.push_back(q);
    quads_planned++;
  endtask

  task automatic write_reg(cfg_reg_e which, logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= which;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (which == CFG_MAP_SIDE) map_side_q = value;
    else cells_log2_q = value[CellsLogW-1:0];
  endtask

  // Wait until every quad has come back, then let the pipeline settle
  task automatic drain();
    while (quads_checked != quads_planned) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Driver: present quads in bursts, record expectations on accepted beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_tris.push_back(stitch_quad(cur_quad));
      end
      if (!start_i || !busy_o) begin
        if (gap_left != 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (quad_queue.size() != 0) begin
          cur_quad = quad_queue.pop_front();
          patch_col_i <= cur_quad.patch_col;
          patch_row_i <= cur_quad.patch_row;
          quad_x_i <= cur_quad.quad_x;
          quad_z_i <= cur_quad.quad_z;
          own_lod_i <= cur_quad.own_lod;
          top_lod_i <= cur_quad.top_lod;
          bottom_lod_i <= cur_quad.bottom_lod;
          left_lod_i <= cur_quad.left_lod;
          right_lod_i <= cur_quad.right_lod;
          start_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            if (steady) gap_left = 0;
            else if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 15);
            else gap_left = $urandom_range(0, 2);
          end else begin
            burst_left--;
          end
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : tri_monitor
    tri_set_t got, want;
    if (rst_ni && done_o) begin
      got = {tri1_c_o, tri1_b_o, tri1_a_o, tri0_c_o, tri0_b_o, tri0_a_o};
      if (expected_tris.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %h", got);
      end else begin
        want = expected_tris.pop_front();
        quads_checked++;
        for (int i = 0; i < 6; i++) begin
          if (got[i] !== want[i]) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("quad %0d %s: expected %0d, got %0d",
                       quads_checked - 1, field_name[i], want[i], got[i]);
            end
          end
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed quads under the reset registers (32 cells, map side 257)
    push_quad(0, 0, 0, 0, 0, -1, -1, -1, -1);
    push_quad(511, 511, 127, 127, 7, 7, 7, 7, 7);
    push_quad(3, 4, 1, 0, 0, 2, -1, -1, -1);     // top edge snap
    push_quad(3, 4, 5, 31, 0, -1, 3, -1, -1);    // bottom edge snap
    push_quad(3, 4, 0, 3, 0, -1, -1, 2, -1);     // left edge snap
    push_quad(3, 4, 31, 5, 0, -1, -1, -1, 2);    // right edge snap
    push_quad(6, 1, 0, 1, 0, 1, -1, 2, -1);      // left edge snap; top edge not reached
    push_quad(7, 2, 30, 30, 1, -1, 3, -1, 4);    // bottom and right meet
    push_quad(1, 1, 4, 0, 2, 2, -1, -1, -1);     // neighbor at same level
    push_quad(1, 1, 8, 0, 3, 1, -1, -1, -1);     // finer neighbor
    push_quad(2, 2, 1, 0, 0, -8, -5, -2, -1);    // absent neighbors
    push_quad(2, 2, 0, 1, 0, -3, -1, -7, -1);
    push_quad(5, 6, 3, 5, 2, 4, 4, 4, 4);        // misaligned origin
    push_quad(1, 1, 100, 40, 0, 7, 7, 7, 7);     // origin outside the patch
    push_quad(0, 0, 0, 0, 7, -1, -1, -1, -1);    // step past the patch
    push_quad(511, 511, 31, 31, 0, -1, -1, -1, -1);
    push_quad(9, 9, 0, 64, 6, -1, -1, 7, -1);
    for (int i = 0; i < 40; i++) begin
      quad_queue.push_back(make_quad($urandom_range(0, 4) != 0));
      quads_planned++;
    end

    // Random phases, each under its own register setting
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      write_reg(CFG_MAP_SIDE, CfgDataW'(side_tab[p]));
      write_reg(CFG_PATCH_CELLS_LOG2, {10'($urandom), 3'(log2_tab[p])});
      settings_run++;
      steady = (p % 3 == 1);
      for (int i = 0; i < QuadsPerPhase; i++) begin
        quad_queue.push_back(make_quad($urandom_range(0, 4) != 0));
        quads_planned++;
      end
    end
    drain();

    $display("checked %0d quads under %0d register settings", quads_checked, settings_run);
    $display("map side 0 to 8191, patch cells log2 0 to 7, %0d mismatches", mismatches);
    if (mismatches == 0 && expected_tris.size() == 0) begin
      $display("lod_patch_index_stitch_test OK");
    end else begin
      $display("lod_patch_index_stitch_test NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("timeout after %0d of %0d quads", quads_checked, quads_planned);
    $display("lod_patch_index_stitch_test NOT OK");
    $finish;
  end

endmodule
